// ===== rtl/papf_pkg.sv =====
// shared types and constants of the pedal actuator position follower
package papf_pkg;

  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned DEADBAND_W = 12;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned POT_BITS_DEFAULT = 12;

  localparam logic [PERIOD_W-1:0]   PWM_PERIOD_RESET   = 16'd999;
  localparam logic [POS_W-1:0]      POSITION_MIN_RESET = 16'd0;
  localparam logic [POS_W-1:0]      POSITION_MAX_RESET = 16'd4095;
  localparam logic [DEADBAND_W-1:0] POT_DEADBAND_RESET = 12'd5;
  localparam logic [PERIOD_W-1:0]   PWM_SLOW_RESET     = PERIOD_W'((3 * 999) / 10);

  // floor(x / 10) as (x * RECIP_TEN) >> RECIP_SHIFT, exact for x below 2^19
  localparam int unsigned RECIP_SHIFT = 22;
  localparam logic [18:0] RECIP_TEN   = 19'd419431;

  localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POSITION_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POSITION_MAX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POT_DEADBAND = 2'd3;

  typedef enum logic [1:0] {
    CMD_POT   = 2'd0,
    CMD_PRESS = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_FWD  = 2'd1,
    PH_BACK = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    DRV_STOP      = 3'd0,
    DRV_SLOW_FWD  = 3'd1,
    DRV_SLOW_BACK = 3'd2,
    DRV_FULL_FWD  = 3'd3,
    DRV_HALF_BACK = 3'd4
  } drive_e;

  typedef struct packed {
    logic   direction;
    logic   moving;
    logic   pressed;
    phase_e phase;
    drive_e drive;
  } ctrl_t;

endpackage

// ===== rtl/pedal_actuator_position_follower.sv =====
// pedal actuator position follower: pot tracking and press sequence drive
//
// Input channel in_valid_i / in_stall_o carries one word per item: a pot
// sample, a press or release event, or a poll tick. Every accepted word
// gives exactly one result word on out_valid_o / out_stall_i with the two
// PWM compare values and the moving, pressed and direction flags.
// A word is registered on entry, worked through the compare and
// clamp logic and lands in the result register, which drives out_valid_o;
// and one word is taken from the input every cycle while the
// receiver keeps up. When the receiver stalls, the result register holds
// and one further word waits in the entry register; in_stall_o then rises.
// The slow duty floor(3P/10) is worked out by one multiplier when
// pwm_period is written, so the item path has no multiplier.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_wdata_i
// while the block is idle. Reset clears all follower state, loads the
// register defaults and leaves both channels empty.
module pedal_actuator_position_follower #(
  parameter int unsigned POT_BITS = papf_pkg::POT_BITS_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [papf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [papf_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          command_i,
  input  logic [POT_BITS-1:0]                 pot_value_i,
  input  logic signed [papf_pkg::POS_W-1:0]   encoder_position_i,
  input  logic                                press_level_i,
  input  logic                                finish_switch_i,
  input  logic                                start_switch_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [papf_pkg::PERIOD_W-1:0]       forward_compare_o,
  output logic [papf_pkg::PERIOD_W-1:0]       reverse_compare_o,
  output logic                                moving_flag_o,
  output logic                                pressed_flag_o,
  output logic                                direction_now_o
);

  localparam int unsigned MAG_W = (POT_BITS > papf_pkg::DEADBAND_W) ?
                                  POT_BITS : papf_pkg::DEADBAND_W;
  localparam int unsigned TW = ((POT_BITS > papf_pkg::POS_W) ?
                                POT_BITS : papf_pkg::POS_W) + 2;
  localparam int unsigned PROD_W = 18 + 19;

  // configuration
  logic [papf_pkg::PERIOD_W-1:0]   period_q;
  logic [papf_pkg::PERIOD_W-1:0]   slow_q;
  logic [papf_pkg::PERIOD_W-1:0]   slow_d;
  logic [papf_pkg::POS_W-1:0]      pos_min_q;
  logic [papf_pkg::POS_W-1:0]      pos_max_q;
  logic [papf_pkg::DEADBAND_W-1:0] deadband_q;
  logic [17:0]                     triple;
  logic [PROD_W-1:0]               prod;

  assign triple = {2'b00, cfg_wdata_i} + {1'b0, cfg_wdata_i, 1'b0};
  assign prod   = PROD_W'(triple) * PROD_W'(papf_pkg::RECIP_TEN);
  assign slow_d = papf_pkg::PERIOD_W'(prod[PROD_W-1:papf_pkg::RECIP_SHIFT]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= papf_pkg::PWM_PERIOD_RESET;
      slow_q     <= papf_pkg::PWM_SLOW_RESET;
      pos_min_q  <= papf_pkg::POSITION_MIN_RESET;
      pos_max_q  <= papf_pkg::POSITION_MAX_RESET;
      deadband_q <= papf_pkg::POT_DEADBAND_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        papf_pkg::CFG_PWM_PERIOD: begin
          period_q <= cfg_wdata_i;
          slow_q   <= slow_d;
        end
        papf_pkg::CFG_POSITION_MIN: pos_min_q  <= cfg_wdata_i;
        papf_pkg::CFG_POSITION_MAX: pos_max_q  <= cfg_wdata_i;
        papf_pkg::CFG_POT_DEADBAND: begin
          deadband_q <= cfg_wdata_i[papf_pkg::DEADBAND_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // entry register
  logic                             in_full_q;
  logic [1:0]                       cmd_q;
  logic [POT_BITS-1:0]              pot_q;
  logic signed [papf_pkg::POS_W-1:0] enc_q;
  logic                             level_q;
  logic                             finish_q;
  logic                             start_q;
  logic                             advance;
  logic                             in_take;
  logic                             out_full_q;

  assign advance    = in_full_q && (!out_full_q || !out_stall_i);
  assign in_stall_o = in_full_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else if (in_take) begin
      in_full_q <= 1'b1;
    end else if (advance) begin
      in_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q    <= command_i;
      pot_q    <= pot_value_i;
      enc_q    <= encoder_position_i;
      level_q  <= press_level_i;
      finish_q <= finish_switch_i;
      start_q  <= start_switch_i;
    end
  end

  // follower state
  papf_pkg::ctrl_t     ctrl_q;
  papf_pkg::ctrl_t     ctrl_d;
  logic [POT_BITS-1:0] prev_pot_q;
  logic [POT_BITS-1:0] prev_pot_d;

  logic signed [POT_BITS:0] diff;
  logic [MAG_W-1:0]         mag;
  logic signed [TW-1:0]     target;
  logic signed [TW-1:0]     pot_s;
  logic signed [TW-1:0]     min_s;
  logic signed [TW-1:0]     max_s;
  logic signed [TW-1:0]     enc_s;

  assign diff  = $signed({1'b0, pot_q}) - $signed({1'b0, prev_pot_q});
  assign mag   = diff[POT_BITS] ? MAG_W'(-diff) : MAG_W'(diff);
  assign pot_s = $signed(TW'({1'b0, pot_q}));
  assign min_s = TW'($signed(pos_min_q));
  assign max_s = TW'($signed(pos_max_q));
  assign enc_s = TW'(enc_q);

  always_comb begin
    ctrl_d     = ctrl_q;
    prev_pot_d = prev_pot_q;
    target     = pot_s;
    case (cmd_q)
      papf_pkg::CMD_POT: begin
        if (mag > MAG_W'(deadband_q)) begin
          if (ctrl_q.moving) begin
            // change is nonzero here, its sign picks the direction
            ctrl_d.direction = diff[POT_BITS];
          end
          ctrl_d.moving = 1'b1;
        end
        if (pot_s <= min_s) begin
          target = min_s;
        end else if (pot_s >= max_s) begin
          target = max_s;
        end
        if (ctrl_d.moving) begin
          if ((ctrl_d.direction && (target - TW'(1) >= enc_s)) ||
              (!ctrl_d.direction && (target + TW'(1) <= enc_s))) begin
            ctrl_d.moving = 1'b0;
            ctrl_d.drive  = papf_pkg::DRV_STOP;
          end else begin
            ctrl_d.drive = ctrl_d.direction ? papf_pkg::DRV_SLOW_BACK :
                                              papf_pkg::DRV_SLOW_FWD;
          end
        end
        prev_pot_d = pot_q;
      end
      papf_pkg::CMD_PRESS: begin
        if (level_q) begin
          ctrl_d.pressed = 1'b1;
          if (!ctrl_q.direction) begin
            ctrl_d.phase = papf_pkg::PH_FWD;
            ctrl_d.drive = papf_pkg::DRV_FULL_FWD;
            if (finish_q) begin
              ctrl_d.drive     = papf_pkg::DRV_STOP;
              ctrl_d.direction = 1'b1;
              ctrl_d.phase     = papf_pkg::PH_IDLE;
            end
          end
        end else if (ctrl_q.pressed && ctrl_q.direction) begin
          ctrl_d.phase = papf_pkg::PH_BACK;
          ctrl_d.drive = papf_pkg::DRV_HALF_BACK;
          if (start_q) begin
            ctrl_d.drive     = papf_pkg::DRV_STOP;
            ctrl_d.pressed   = 1'b0;
            ctrl_d.direction = 1'b0;
            ctrl_d.phase     = papf_pkg::PH_IDLE;
          end
        end
      end
      papf_pkg::CMD_TICK: begin
        case (ctrl_q.phase)
          papf_pkg::PH_FWD: begin
            if (ctrl_q.pressed && !ctrl_q.direction) begin
              ctrl_d.drive = papf_pkg::DRV_FULL_FWD;
              if (finish_q) begin
                ctrl_d.drive     = papf_pkg::DRV_STOP;
                ctrl_d.direction = 1'b1;
                ctrl_d.phase     = papf_pkg::PH_IDLE;
              end
            end else begin
              ctrl_d.phase = papf_pkg::PH_IDLE;
            end
          end
          papf_pkg::PH_BACK: begin
            if (ctrl_q.pressed && ctrl_q.direction) begin
              ctrl_d.drive = papf_pkg::DRV_HALF_BACK;
              if (start_q) begin
                ctrl_d.drive     = papf_pkg::DRV_STOP;
                ctrl_d.pressed   = 1'b0;
                ctrl_d.direction = 1'b0;
                ctrl_d.phase     = papf_pkg::PH_IDLE;
              end
            end else begin
              ctrl_d.phase = papf_pkg::PH_IDLE;
            end
          end
          default: ctrl_d.phase = papf_pkg::PH_IDLE;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q     <= '{direction: 1'b0, moving: 1'b0, pressed: 1'b0,
                      phase: papf_pkg::PH_IDLE, drive: papf_pkg::DRV_STOP};
      prev_pot_q <= '0;
    end else if (advance) begin
      ctrl_q     <= ctrl_d;
      prev_pot_q <= prev_pot_d;
    end
  end

  // compare values from the new drive level
  logic [papf_pkg::PERIOD_W-1:0] fwd_d;
  logic [papf_pkg::PERIOD_W-1:0] rev_d;

  always_comb begin
    fwd_d = '0;
    rev_d = '0;
    case (ctrl_d.drive)
      papf_pkg::DRV_SLOW_FWD:  fwd_d = slow_q;
      papf_pkg::DRV_SLOW_BACK: rev_d = slow_q;
      papf_pkg::DRV_FULL_FWD:  fwd_d = period_q;
      papf_pkg::DRV_HALF_BACK: rev_d = period_q >> 1;
      default: ;
    endcase
  end

  // result register
  logic [papf_pkg::PERIOD_W-1:0] out_fwd_q;
  logic [papf_pkg::PERIOD_W-1:0] out_rev_q;
  logic                          out_moving_q;
  logic                          out_pressed_q;
  logic                          out_dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_full_q <= 1'b0;
    end else if (advance) begin
      out_full_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_fwd_q     <= fwd_d;
      out_rev_q     <= rev_d;
      out_moving_q  <= ctrl_d.moving;
      out_pressed_q <= ctrl_d.pressed;
      out_dir_q     <= ctrl_d.direction;
    end
  end

  assign out_valid_o       = out_full_q;
  assign forward_compare_o = out_fwd_q;
  assign reverse_compare_o = out_rev_q;
  assign moving_flag_o     = out_moving_q;
  assign pressed_flag_o    = out_pressed_q;
  assign direction_now_o   = out_dir_q;

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench of the pedal actuator position follower
`timescale 1ns / 1ps

module testbench;
  import papf_pkg::*;

  localparam int unsigned POT_W = POT_BITS_DEFAULT;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int LONG_HOLD = 64;
  localparam int HOLD_AFTER = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_CAP = 200;

  typedef struct {
    logic [1:0]         command;
    logic [POT_W-1:0]   pot;
    logic signed [15:0] enc;
    logic               level;
    logic               finish;
    logic               start;
  } pedal_word_t;

  typedef struct {
    logic [PERIOD_W-1:0] fwd;
    logic [PERIOD_W-1:0] rev;
    logic                moving;
    logic                pressed;
    logic                dir;
  } drive_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] command_i = '0;
  logic [POT_W-1:0] pot_value_i = '0;
  logic signed [POS_W-1:0] encoder_position_i = '0;
  logic press_level_i = 1'b0;
  logic finish_switch_i = 1'b0;
  logic start_switch_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [PERIOD_W-1:0] forward_compare_o;
  logic [PERIOD_W-1:0] reverse_compare_o;
  logic moving_flag_o;
  logic pressed_flag_o;
  logic direction_now_o;

  pedal_actuator_position_follower i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .pot_value_i        (pot_value_i),
    .encoder_position_i (encoder_position_i),
    .press_level_i      (press_level_i),
    .finish_switch_i    (finish_switch_i),
    .start_switch_i     (start_switch_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .forward_compare_o  (forward_compare_o),
    .reverse_compare_o  (reverse_compare_o),
    .moving_flag_o      (moving_flag_o),
    .pressed_flag_o     (pressed_flag_o),
    .direction_now_o    (direction_now_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // follower state and register copies of the predictor
  int period_cfg = PWM_PERIOD_RESET;
  int pos_lo_cfg = $signed(POSITION_MIN_RESET);
  int pos_hi_cfg = $signed(POSITION_MAX_RESET);
  int deadband_cfg = POT_DEADBAND_RESET;
  logic [POT_W-1:0] prev_pot_m = '0;
  bit dir_m = 1'b0;
  bit moving_m = 1'b0;
  bit pressed_m = 1'b0;
  phase_e phase_m = PH_IDLE;
  drive_e drive_m = DRV_STOP;

  pedal_word_t pending_words[$];
  drive_result_t expected_results[$];
  pedal_word_t offered;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;
  bit no_idling = 1'b0;
  int results_seen = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int run_pot = 0;

  function automatic void forward_pass(logic finish);
    drive_m = DRV_FULL_FWD;
    if (finish) begin
      drive_m = DRV_STOP;
      dir_m = 1'b1;
      phase_m = PH_IDLE;
    end
  endfunction

  function automatic void back_pass(logic start);
    drive_m = DRV_HALF_BACK;
    if (start) begin
      drive_m = DRV_STOP;
      pressed_m = 1'b0;
      dir_m = 1'b0;
      phase_m = PH_IDLE;
    end
  endfunction

  function automatic drive_result_t follow_word(pedal_word_t w);
    drive_result_t r;
    int diff;
    int mag;
    int tgt;
    int slow;
    case (w.command)
      CMD_POT: begin
        diff = int'(w.pot) - int'(prev_pot_m);
        mag = (diff < 0) ? -diff : diff;
        if (mag > deadband_cfg) begin
          if (moving_m) begin
            if (diff < 0) dir_m = 1'b1;
            else if (diff > 0) dir_m = 1'b0;
          end
          moving_m = 1'b1;
        end
        if (moving_m) begin
          tgt = int'(w.pot);
          if (tgt <= pos_lo_cfg) tgt = pos_lo_cfg;
          else if (tgt >= pos_hi_cfg) tgt = pos_hi_cfg;
          // stop once the encoder is one past the target
          if ((dir_m && tgt - 1 >= int'(w.enc)) || (!dir_m && tgt + 1 <= int'(w.enc))) begin
            moving_m = 1'b0;
            drive_m = DRV_STOP;
          end else begin
            drive_m = dir_m ? DRV_SLOW_BACK : DRV_SLOW_FWD;
          end
        end
        prev_pot_m = w.pot;
      end
      CMD_PRESS: begin
        if (w.level) begin
          pressed_m = 1'b1;
          if (!dir_m) begin
            phase_m = PH_FWD;
            forward_pass(w.finish);
          end
        end else if (pressed_m && dir_m) begin
          phase_m = PH_BACK;
          back_pass(w.start);
        end
      end
      CMD_TICK: begin
        case (phase_m)
          PH_FWD: begin
            if (pressed_m && !dir_m) forward_pass(w.finish);
            else phase_m = PH_IDLE;
          end
          PH_BACK: begin
            if (pressed_m && dir_m) back_pass(w.start);
            else phase_m = PH_IDLE;
          end
          default: phase_m = PH_IDLE;
        endcase
      end
      default: ;
    endcase
    slow = (3 * period_cfg) / 10;
    r.fwd = '0;
    r.rev = '0;
    case (drive_m)
      DRV_SLOW_FWD:  r.fwd = 16'(slow);
      DRV_SLOW_BACK: r.rev = 16'(slow);
      DRV_FULL_FWD:  r.fwd = 16'(period_cfg);
      DRV_HALF_BACK: r.rev = 16'(period_cfg / 2);
      default: ;
    endcase
    r.moving = moving_m;
    r.pressed = pressed_m;
    r.dir = dir_m;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    // keep the log readable when the block is badly off
    if (mismatches < PRINT_CAP) $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // input side: offer the oldest pending word, predict on acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) expected_results.push_back(follow_word(offered));
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() != 0) begin
          offered = pending_words.pop_front();
          command_i <= offered.command;
          pot_value_i <= offered.pot;
          encoder_position_i <= offered.enc;
          press_level_i <= offered.level;
          finish_switch_i <= offered.finish;
          start_switch_i <= offered.start;
          in_valid_i <= 1'b1;
          if (!no_idling && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 4);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // output side stall: short random bursts plus one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!no_idling && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : compare_results
    drive_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = expected_results.pop_front();
        check_field("forward_compare", forward_compare_o, want.fwd);
        check_field("reverse_compare", reverse_compare_o, want.rev);
        check_field("moving_flag", moving_flag_o, want.moving);
        check_field("pressed_flag", pressed_flag_o, want.pressed);
        check_field("direction_now", direction_now_o, want.dir);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_word(logic [1:0] cmd, int pot, int enc, bit level, bit fin, bit st);
    pedal_word_t w;
    w.command = cmd;
    w.pot = POT_W'(pot);
    w.enc = 16'(enc);
    w.level = level;
    w.finish = fin;
    w.start = st;
    pending_words.push_back(w);
  endtask

  function automatic pedal_word_t any_word(logic [1:0] cmd);
    pedal_word_t w;
    w.command = cmd;
    w.pot = POT_W'($urandom_range(0, (1 << POT_W) - 1));
    w.enc = 16'($urandom_range(0, 65535));
    w.level = 1'($urandom_range(0, 1));
    w.finish = ($urandom_range(0, 3) == 0);
    w.start = ($urandom_range(0, 3) == 0);
    return w;
  endfunction

  // pot walk with the encoder mostly parked around the clamped target
  function automatic pedal_word_t pot_word();
    pedal_word_t w;
    int tgt;
    w = any_word(CMD_POT);
    if ($urandom_range(0, 7) == 0) run_pot = $urandom_range(0, (1 << POT_W) - 1);
    else if ($urandom_range(0, 3) == 0) run_pot = run_pot + $urandom_range(0, 800) - 400;
    else run_pot = run_pot + $urandom_range(0, 16) - 8;
    if (run_pot < 0) run_pot = 0;
    if (run_pot > (1 << POT_W) - 1) run_pot = (1 << POT_W) - 1;
    w.pot = POT_W'(run_pot);
    tgt = run_pot;
    if (tgt <= pos_lo_cfg) tgt = pos_lo_cfg;
    else if (tgt >= pos_hi_cfg) tgt = pos_hi_cfg;
    if ($urandom_range(0, 2) != 0) w.enc = 16'(tgt + $urandom_range(0, 6) - 3);
    return w;
  endfunction

  task automatic queue_chunk();
    int pick;
    int n;
    pedal_word_t w;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      // press, polls until the finish switch, release, polls until home
      w = any_word(CMD_PRESS);
      w.level = 1'b1;
      w.finish = ($urandom_range(0, 7) == 0);
      pending_words.push_back(w);
      n = $urandom_range(0, 5);
      repeat (n) begin
        w = ($urandom_range(0, 4) == 0) ? pot_word() : any_word(CMD_TICK);
        w.finish = 1'b0;
        pending_words.push_back(w);
      end
      w = any_word(CMD_TICK);
      w.finish = 1'b1;
      pending_words.push_back(w);
      w = any_word(CMD_PRESS);
      w.level = 1'b0;
      w.start = ($urandom_range(0, 7) == 0);
      pending_words.push_back(w);
      n = $urandom_range(0, 5);
      repeat (n) begin
        w = ($urandom_range(0, 4) == 0) ? pot_word() : any_word(CMD_TICK);
        w.start = 1'b0;
        pending_words.push_back(w);
      end
      w = any_word(CMD_TICK);
      w.start = 1'b1;
      pending_words.push_back(w);
    end else if (pick < 75) begin
      n = $urandom_range(2, 8);
      repeat (n) pending_words.push_back(pot_word());
    end else if (pick < 95) begin
      pending_words.push_back(any_word(2'($urandom_range(0, 2))));
    end else begin
      pending_words.push_back(any_word(CMD_UNUSED));
    end
  endtask

  task automatic queue_random(int n);
    while (pending_words.size() < n) queue_chunk();
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_register(logic [CFG_IDX_W-1:0] idx, int value);
    logic [15:0] v16;
    v16 = value[15:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v16;
    case (idx)
      CFG_PWM_PERIOD:   period_cfg = int'(v16);
      CFG_POSITION_MIN: pos_lo_cfg = int'($signed(v16));
      CFG_POSITION_MAX: pos_hi_cfg = int'($signed(v16));
      CFG_POT_DEADBAND: deadband_cfg = int'(v16[DEADBAND_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic apply_setting(int period, int lo, int hi, int deadband);
    set_register(CFG_PWM_PERIOD, period);
    set_register(CFG_POSITION_MIN, lo);
    set_register(CFG_POSITION_MAX, hi);
    set_register(CFG_POT_DEADBAND, deadband);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_word(CMD_POT, 0, 0, 0, 0, 0);
    push_word(CMD_POT, 4095, -32768, 1, 1, 1);   // move starts, clamps at max
    push_word(CMD_POT, 0, 32767, 0, 0, 0);       // reversal while moving, clamps at min
    push_word(CMD_POT, 6, 7, 0, 0, 0);           // forward, encoder one past target
    push_word(CMD_POT, 11, 0, 0, 0, 0);          // change equal to deadband
    push_word(CMD_POT, 17, 17, 0, 0, 0);
    push_word(CMD_POT, 17, 18, 0, 0, 0);
    push_word(CMD_PRESS, 100, 0, 1, 0, 0);
    push_word(CMD_TICK, 200, 5, 0, 0, 1);
    push_word(CMD_TICK, 300, 5, 0, 1, 0);        // finish switch turns direction back
    push_word(CMD_TICK, 0, 0, 0, 0, 0);          // idle poll
    push_word(CMD_PRESS, 0, 0, 1, 0, 0);         // press while direction is back
    push_word(CMD_PRESS, 0, 0, 0, 1, 0);
    push_word(CMD_TICK, 0, 0, 0, 0, 0);
    push_word(CMD_POT, 4000, 3999, 0, 0, 0);     // back, encoder one short of target
    push_word(CMD_TICK, 0, 0, 0, 0, 1);          // home switch ends the press
    push_word(CMD_PRESS, 0, 0, 0, 0, 1);         // release with nothing pressed
    push_word(CMD_UNUSED, 4095, -1, 1, 1, 1);
    push_word(CMD_TICK, 4095, 32767, 1, 1, 1);
    push_word(CMD_PRESS, 0, 0, 1, 1, 0);         // finish already reached on press
    push_word(CMD_PRESS, 0, 0, 0, 0, 1);         // home already reached on release
    push_word(CMD_PRESS, 50, 0, 1, 0, 0);
    push_word(CMD_POT, 0, 0, 0, 0, 0);           // pot move during forward phase
    push_word(CMD_TICK, 0, 0, 0, 0, 0);
    queue_random(290);
    wait_drained();

    apply_setting(65535, -32768, 32767, 0);
    queue_random(290);
    wait_drained();

    apply_setting(0, 2000, 2000, 4095);
    queue_random(290);
    wait_drained();

    apply_setting(1, 3000, 1000, 1);             // crossed limits
    queue_random(290);
    wait_drained();

    apply_setting($urandom_range(2, 65534), $urandom_range(0, 2000),
                  $urandom_range(2001, 4095), $urandom_range(0, 20));
    queue_random(290);
    wait_drained();

    no_idling <= 1'b1;
    apply_setting(999, 0, 4095, 5);
    queue_random(290);
    wait_drained();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
